### rtl/akbc_pkg.sv
// ----------------------------------------------------------------------------
// akbc_pkg
// Shared types, constants and helper functions of the autokey byte cipher.
// ----------------------------------------------------------------------------
package akbc_pkg;

  localparam logic [31:0] KeyMul   = 32'd53761;
  localparam logic [31:0] KeyAdd   = 32'd32618;
  localparam logic [31:0] KeyReset = 32'd5;

  // Configuration register indexes.
  localparam logic CfgMode   = 1'b0;
  localparam logic CfgDefKey = 1'b1;

  // Mode register values.
  localparam logic ModeEncrypt = 1'b0;
  localparam logic ModeDecrypt = 1'b1;

  // Input item kinds.
  localparam logic KindData  = 1'b0;
  localparam logic KindStart = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_ENC,
    OP_DEC
  } akbc_op_e;

  // One operation handed from the front end to the cipher core.
  typedef struct packed {
    akbc_op_e    op;
    logic [31:0] data;
    logic        bad;
  } akbc_op_t;

  // Uppercase ASCII character of a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'b0000, nib};
    if (nib < 4'd10) begin
      return 8'h30 + ext;
    end
    return 8'h37 + ext;
  endfunction

  // Digit value of an ASCII hex character; bit 4 is set for a non-hex character.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b0, d[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b0, d[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b0, d[3:0]};
    end
    return 5'b10000;
  endfunction

endpackage

### rtl/akbc_if.sv
// ----------------------------------------------------------------------------
// akbc_in_if / akbc_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface akbc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_char;
  logic [31:0] start_key;
  logic        final_req;

  modport source (output valid, kind, data_char, start_key, final_req, input ready);
  modport sink   (input valid, kind, data_char, start_key, final_req, output ready);
endinterface

interface akbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       bad_digit;

  modport source (output valid, out_byte, last, bad_digit, input ready);
  modport sink   (input valid, out_byte, last, bad_digit, output ready);
endinterface

### rtl/akbc_front.sv
// ----------------------------------------------------------------------------
// akbc_front
// Accepts input words, pairs hex digits in decrypt mode and issues operations.
// ----------------------------------------------------------------------------
module akbc_front
  import akbc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         mode_i,
  input  logic [31:0]  default_key_i,
  akbc_in_if.sink      in_if,
  input  logic         push_ready_i,
  output logic         push_valid_o,
  output akbc_op_t     push_data_o
);

  logic       accept;
  logic [4:0] digit;
  logic       dgt_bad;
  logic       issue;
  logic [3:0] held_digit_q, held_digit_d;
  logic       digit_held_q, digit_held_d;
  logic       held_bad_q, held_bad_d;

  assign in_if.ready = push_ready_i;
  assign accept      = in_if.valid && push_ready_i;
  assign digit       = hex_value(in_if.data_char);
  assign dgt_bad     = digit[4];

  always_comb begin
    issue             = 1'b0;
    push_data_o.op    = OP_LOAD;
    push_data_o.data  = 32'd0;
    push_data_o.bad   = 1'b0;
    held_digit_d      = held_digit_q;
    digit_held_d      = digit_held_q;
    held_bad_d        = held_bad_q;
    if (in_if.kind == KindStart) begin
      issue            = 1'b1;
      push_data_o.op   = OP_LOAD;
      push_data_o.data = (in_if.start_key != 32'd0) ? in_if.start_key : default_key_i;
      held_digit_d     = 4'd0;
      digit_held_d     = 1'b0;
      held_bad_d       = 1'b0;
    end else if (mode_i == ModeEncrypt) begin
      issue            = 1'b1;
      push_data_o.op   = OP_ENC;
      push_data_o.data = {24'd0, in_if.data_char};
    end else if (digit_held_q) begin
      issue          = 1'b1;
      push_data_o.op = OP_DEC;
      if (held_bad_q) begin
        push_data_o.bad = 1'b1;
      end else if (dgt_bad) begin
        push_data_o.data = {28'd0, held_digit_q};
        push_data_o.bad  = 1'b1;
      end else begin
        push_data_o.data = {24'd0, held_digit_q, digit[3:0]};
      end
      held_digit_d = 4'd0;
      digit_held_d = 1'b0;
      held_bad_d   = 1'b0;
    end else if (in_if.final_req) begin
      issue            = 1'b1;
      push_data_o.op   = OP_DEC;
      push_data_o.data = dgt_bad ? 32'd0 : {28'd0, digit[3:0]};
      push_data_o.bad  = dgt_bad;
    end else begin
      digit_held_d = 1'b1;
      held_bad_d   = dgt_bad;
      held_digit_d = dgt_bad ? 4'd0 : digit[3:0];
    end
  end

  assign push_valid_o = accept && issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_digit_q <= 4'd0;
      digit_held_q <= 1'b0;
      held_bad_q   <= 1'b0;
    end else if (accept) begin
      held_digit_q <= held_digit_d;
      digit_held_q <= digit_held_d;
      held_bad_q   <= held_bad_d;
    end
  end

endmodule

### rtl/akbc_fifo.sv
// ----------------------------------------------------------------------------
// akbc_fifo
// Short operation queue between the front end and the cipher core.
// ----------------------------------------------------------------------------
module akbc_fifo
  import akbc_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  input  akbc_op_t push_data_i,
  output logic     push_ready_o,
  output logic     pop_valid_o,
  output akbc_op_t pop_data_o,
  input  logic     pop_ready_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  akbc_op_t        entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/akbc_core.sv
// ----------------------------------------------------------------------------
// akbc_core
// Holds the running key, ciphers one byte per operation and drives results.
// ----------------------------------------------------------------------------
module akbc_core
  import akbc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       op_valid_i,
  input  akbc_op_t   op_data_i,
  output logic       op_ready_o,
  akbc_out_if.source out_if
);

  logic [31:0] key_q;
  logic [31:0] key_sum;
  logic [31:0] key_next;
  logic [7:0]  pad;
  logic [7:0]  enc_byte;
  logic [7:0]  feed;
  logic        out_free;
  logic        take;
  logic        pend_q;
  logic [7:0]  pend_char_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        last_q;
  logic        bad_q;

  assign pad      = key_q[15:8];
  assign enc_byte = op_data_i.data[7:0] ^ pad;
  assign feed     = (op_data_i.op == OP_ENC) ? enc_byte : op_data_i.data[7:0];
  assign key_sum  = key_q + {24'd0, feed};
  assign key_next = key_sum * KeyMul + KeyAdd;

  assign out_free   = !out_valid_q || out_if.ready;
  assign op_ready_o = (op_data_i.op == OP_LOAD) || (!pend_q && out_free);
  assign take       = op_valid_i && op_ready_o;

  assign out_if.valid     = out_valid_q;
  assign out_if.out_byte  = out_byte_q;
  assign out_if.last      = last_q;
  assign out_if.bad_digit = bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= KeyReset;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        key_q <= (op_data_i.op == OP_LOAD) ? op_data_i.data : key_next;
      end
      if (pend_q && out_free) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else if (take && op_data_i.op != OP_LOAD) begin
        out_valid_q <= 1'b1;
        pend_q      <= (op_data_i.op == OP_ENC);
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q && out_free) begin
      out_byte_q <= pend_char_q;
      last_q     <= 1'b1;
      bad_q      <= 1'b0;
    end else if (take) begin
      case (op_data_i.op)
        OP_ENC: begin
          out_byte_q  <= hex_char(enc_byte[7:4]);
          pend_char_q <= hex_char(enc_byte[3:0]);
          last_q      <= 1'b0;
          bad_q       <= 1'b0;
        end
        OP_DEC: begin
          out_byte_q <= enc_byte;
          last_q     <= 1'b1;
          bad_q      <= op_data_i.bad;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/autokey_byte_cipher_hex.sv
// ----------------------------------------------------------------------------
// autokey_byte_cipher_hex
// Byte autokey stream cipher with a 32-bit running key and hex text framing.
// ----------------------------------------------------------------------------
// Input words arrive on in_if and result words leave on out_if, both with a
// valid/ready handshake. A start word loads the running key from start_key, or
// from the default key register when start_key is zero, and yields no result.
// In encrypt mode every data word yields two uppercase hex characters; in
// decrypt mode every pair of hex characters yields one plain byte.
// The front end takes one word per cycle into a short operation queue while
// the queue has room. The cipher core retires one operation per cycle while
// the output register is free and no low hex character is pending; its key
// update (one add, one constant multiply, one add) is combinational. The
// output register sends one result per cycle while the receiver is ready.
// A result word passes the operation queue and then the output register.
// When the receiver stalls, the output register holds its word, the queue
// fills, and in_if.ready drops once the queue is full.
// Reset clears the queue and the output, sets the running key and default key
// to five and selects encrypt mode. Configuration writes belong in idle time.
// ----------------------------------------------------------------------------
module autokey_byte_cipher_hex
  import akbc_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  akbc_in_if.sink     in_if,
  akbc_out_if.source  out_if,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  logic        mode_q;
  logic [31:0] default_key_q;
  logic        push_valid, push_ready;
  akbc_op_t    push_data;
  logic        op_valid, op_ready;
  akbc_op_t    op_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= ModeEncrypt;
      default_key_q <= KeyReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMode:   mode_q        <= cfg_wdata_i[0];
        CfgDefKey: default_key_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  akbc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_q),
    .default_key_i (default_key_q),
    .in_if         (in_if),
    .push_ready_i  (push_ready),
    .push_valid_o  (push_valid),
    .push_data_o   (push_data)
  );

  akbc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (op_valid),
    .pop_data_o   (op_data),
    .pop_ready_i  (op_ready)
  );

  akbc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_data_i  (op_data),
    .op_ready_o (op_ready),
    .out_if     (out_if)
  );

endmodule

### rtl/akbc_checker.sv
// ----------------------------------------------------------------------------
// akbc_checker
// Port-level checks on the result channel of the autokey byte cipher.
// ----------------------------------------------------------------------------
module akbc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i,
  input logic       out_bad_i
);

  // A stalled result word stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

  a_bad_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_bad_i |-> out_last_i)
    else $error("bad digit flag on a non-final result");

  // Only the high nibble of an encrypted byte is sent without last.
  a_first_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |->
      (out_byte_i >= 8'h30 && out_byte_i <= 8'h39) ||
      (out_byte_i >= 8'h41 && out_byte_i <= 8'h46))
    else $error("first character of a pair is not uppercase hex");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> !out_valid_i || out_last_i)
    else $error("high hex character not followed by the low one");

endmodule

bind autokey_byte_cipher_hex akbc_checker u_akbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_byte_i  (out_if.out_byte),
  .out_last_i  (out_if.last),
  .out_bad_i   (out_if.bad_digit)
);

### test/akbc_result_check.sv
// ----------------------------------------------------------------------------
// akbc_result_check
// Watches the input, output and configuration ports of the autokey cipher,
// predicts every result word from its own copy of the key state and compares
// the words that leave the block with the predictions, in order.
// ----------------------------------------------------------------------------
module akbc_result_check
  import akbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  akbc_in_if          in_if,
  akbc_out_if         out_if,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiNine = 8'h39;
  localparam logic [7:0] AsciiUpA  = 8'h41;
  localparam logic [7:0] AsciiUpF  = 8'h46;
  localparam logic [7:0] AsciiLowA = 8'h61;
  localparam logic [7:0] AsciiLowF = 8'h66;

  typedef struct {
    logic [7:0] out_byte;
    logic       last;
    logic       bad_digit;
  } result_t;

  result_t     cipher_words_q[$];
  result_t     got;
  result_t     want;
  logic        mode_q;
  logic [31:0] default_key_q;
  logic [31:0] key_q;
  logic [3:0]  held_nib_q;
  logic        nib_held_q;
  logic        held_bad_q;
  logic [7:0]  cbyte;
  logic [7:0]  pair;
  logic        pair_bad;
  logic        emit;
  logic [4:0]  digit;

  function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
    if (n > 4'd9) begin
      return AsciiUpA + 8'(n - 4'd10);
    end
    return AsciiZero + 8'(n);
  endfunction

  // Bit 4 flags a character that is not a hex digit.
  function automatic logic [4:0] ascii_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= AsciiZero && c <= AsciiNine) begin
      v = c - AsciiZero;
    end else if (c >= AsciiUpA && c <= AsciiUpF) begin
      v = c - AsciiUpA + 8'd10;
    end else if (c >= AsciiLowA && c <= AsciiLowF) begin
      v = c - AsciiLowA + 8'd10;
    end else begin
      return 5'b10000;
    end
    return {1'b0, v[3:0]};
  endfunction

  function automatic logic [31:0] next_key(input logic [31:0] key, input logic [7:0] c);
    return (key + 32'(c)) * KeyMul + KeyAdd;
  endfunction

  task automatic push_word(input logic [7:0] b, input logic l, input logic bad);
    result_t r;
    r.out_byte  = b;
    r.last      = l;
    r.bad_digit = bad;
    cipher_words_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_words_q.delete();
      mode_q        = ModeEncrypt;
      default_key_q = KeyReset;
      key_q         = KeyReset;
      held_nib_q    = 4'h0;
      nib_held_q    = 1'b0;
      held_bad_q    = 1'b0;
      fail_cnt_o    = 0;
      pending_o     = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgMode) begin
          mode_q = cfg_wdata_i[0];
        end else if (cfg_idx_i == CfgDefKey) begin
          default_key_q = cfg_wdata_i;
        end
      end

      if (out_if.valid && out_if.ready) begin
        got.out_byte  = out_if.out_byte;
        got.last      = out_if.last;
        got.bad_digit = out_if.bad_digit;
        if (cipher_words_q.size() == 0) begin
          $error("unexpected result word: out_byte %h last %b bad_digit %b",
                 got.out_byte, got.last, got.bad_digit);
          fail_cnt_o++;
        end else begin
          want = cipher_words_q.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
            fail_cnt_o++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, got.last);
            fail_cnt_o++;
          end
          if (got.bad_digit !== want.bad_digit) begin
            $error("bad_digit: expected %b, got %b", want.bad_digit, got.bad_digit);
            fail_cnt_o++;
          end
        end
      end

      if (in_if.valid && in_if.ready) begin
        if (in_if.kind == KindStart) begin
          key_q      = (in_if.start_key != 32'd0) ? in_if.start_key : default_key_q;
          held_nib_q = 4'h0;
          nib_held_q = 1'b0;
          held_bad_q = 1'b0;
        end else if (mode_q == ModeEncrypt) begin
          cbyte = in_if.data_char ^ key_q[15:8];
          key_q = next_key(key_q, cbyte);
          push_word(nibble_ascii(cbyte[7:4]), 1'b0, 1'b0);
          push_word(nibble_ascii(cbyte[3:0]), 1'b1, 1'b0);
        end else begin
          digit    = ascii_nibble(in_if.data_char);
          emit     = 1'b1;
          pair     = 8'h00;
          pair_bad = 1'b0;
          if (nib_held_q) begin
            if (held_bad_q) begin
              pair     = 8'h00;
              pair_bad = 1'b1;
            end else if (digit[4]) begin
              pair     = {4'h0, held_nib_q};
              pair_bad = 1'b1;
            end else begin
              pair     = {held_nib_q, digit[3:0]};
              pair_bad = 1'b0;
            end
            nib_held_q = 1'b0;
            held_nib_q = 4'h0;
            held_bad_q = 1'b0;
          end else if (in_if.final_req) begin
            // A lone trailing character is parsed as a pair of its own.
            pair     = digit[4] ? 8'h00 : {4'h0, digit[3:0]};
            pair_bad = digit[4];
          end else begin
            nib_held_q = 1'b1;
            held_bad_q = digit[4];
            held_nib_q = digit[4] ? 4'h0 : digit[3:0];
            emit       = 1'b0;
          end
          if (emit) begin
            push_word(pair ^ key_q[15:8], 1'b1, pair_bad);
            key_q = next_key(key_q, pair);
          end
        end
      end

      pending_o = cipher_words_q.size();
    end
  end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the autokey cipher with directed and random words in both modes.
// A directed part covers key loading, pair parsing, bad digits, lone trailing
// characters and a held digit across a mode change; random messages follow
// under several register settings, with random gaps on both channels. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
  import akbc_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_idx;
  logic [31:0] cfg_wdata;
  int          fail_cnt;
  int          pending;
  int          cycle_cnt = 0;
  int          tx_calm   = 0;
  int          rx_stall  = 0;
  int          rx_calm   = 0;

  akbc_in_if  in_if ();
  akbc_out_if out_if ();

  autokey_byte_cipher_hex dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  akbc_result_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(13, 40);
  endfunction

  function automatic logic [7:0] hex_text(input logic [3:0] n, input logic lower);
    if (n < 4'd10) begin
      return 8'h30 + 8'(n);
    end
    return (lower ? 8'h61 : 8'h41) + 8'(n - 4'd10);
  endfunction

  always @(posedge clk_i) begin
    if (rx_calm > 0) begin
      rx_calm--;
      out_if.ready <= 1'b1;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_if.ready <= 1'b0;
    end else begin
      rx_stall = idle_len();
      if ($urandom_range(0, 39) == 0) begin
        rx_calm = $urandom_range(20, 100);
      end
      out_if.ready <= (rx_stall == 0);
    end
  end

  // Returns at the clock edge at which the word was taken; valid stays high.
  task automatic send_word(input logic kind, input logic [7:0] ch,
                           input logic [31:0] skey, input logic fin);
    int gap;
    gap = 0;
    if (tx_calm > 0) begin
      tx_calm--;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 39) == 0) begin
        tx_calm = $urandom_range(20, 100);
      end
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= kind;
    in_if.data_char <= ch;
    in_if.start_key <= skey;
    in_if.final_req <= fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic quiesce();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic mode, input logic [31:0] dkey, input int n_items);
    int          sent;
    int          len;
    int          pick;
    logic [31:0] skey;
    logic [7:0]  ch;
    logic        fin;
    sent = 0;
    write_reg(CfgMode, {31'd0, mode});
    write_reg(CfgDefKey, dkey);
    while (sent < n_items) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if ($urandom_range(0, 9) != 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          skey = 32'd0;
        end else if (pick == 2) begin
          skey = 32'hFFFF_FFFF;
        end else if (pick == 3) begin
          skey = 32'd1;
        end else begin
          skey = $urandom;
        end
        send_word(KindStart, 8'($urandom), skey, 1'($urandom));
        sent++;
      end
      for (int i = 0; i < len; i++) begin
        if (i == len - 1) begin
          fin = ($urandom_range(0, 7) != 0);
        end else begin
          fin = ($urandom_range(0, 29) == 0);
        end
        if (mode == ModeDecrypt && $urandom_range(0, 19) != 0) begin
          ch = hex_text(4'($urandom), 1'($urandom));
        end else begin
          ch = 8'($urandom);
        end
        send_word(KindData, ch, $urandom, fin);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CfgMode;
    cfg_wdata       = 32'd0;
    in_if.valid     = 1'b0;
    in_if.kind      = KindData;
    in_if.data_char = 8'h00;
    in_if.start_key = 32'd0;
    in_if.final_req = 1'b0;
    out_if.ready    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Encrypt with the reset key, then with loaded keys.
    send_word(KindData, 8'h00, 32'd0, 1'b1);
    send_word(KindData, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    send_word(KindStart, 8'hFF, 32'd0, 1'b1);
    send_word(KindData, 8'hA5, 32'd0, 1'b0);
    send_word(KindStart, 8'h00, 32'hFFFF_FFFF, 1'b0);
    send_word(KindData, 8'h5A, 32'd0, 1'b0);

    // Decrypt: good pairs, bad digits, lone trailing characters.
    write_reg(CfgDefKey, 32'hFFFF_FFFF);
    write_reg(CfgMode, {31'd0, ModeDecrypt});
    send_word(KindStart, 8'h00, 32'd0, 1'b0);
    send_word(KindData, "0", 32'd0, 1'b0);
    send_word(KindData, "9", 32'd0, 1'b0);
    send_word(KindData, "a", 32'd0, 1'b0);
    send_word(KindData, "F", 32'd0, 1'b0);
    send_word(KindData, "G", 32'd0, 1'b0);
    send_word(KindData, "1", 32'd0, 1'b0);
    send_word(KindData, "7", 32'd0, 1'b0);
    send_word(KindData, "z", 32'd0, 1'b0);
    send_word(KindData, "3", 32'd0, 1'b1);
    send_word(KindData, 8'h00, 32'd0, 1'b1);
    send_word(KindData, "B", 32'd0, 1'b0);
    send_word(KindData, "C", 32'd0, 1'b1);

    // A held digit survives a trip through encrypt mode.
    send_word(KindData, "E", 32'd0, 1'b0);
    write_reg(CfgMode, {31'd0, ModeEncrypt});
    send_word(KindData, 8'h3C, 32'd0, 1'b0);
    write_reg(CfgMode, {31'd0, ModeDecrypt});
    send_word(KindData, "5", 32'd0, 1'b0);

    // A start word drops a held digit.
    send_word(KindData, "1", 32'd0, 1'b0);
    send_word(KindStart, 8'h00, 32'd1, 1'b0);
    send_word(KindData, "D", 32'd0, 1'b1);

    run_phase(ModeEncrypt, $urandom, 150);
    run_phase(ModeDecrypt, 32'd0, 150);
    run_phase(ModeDecrypt, 32'hFFFF_FFFF, 150);
    run_phase(ModeEncrypt, 32'hFFFF_FFFF, 150);
    run_phase(ModeDecrypt, $urandom, 150);
    run_phase(ModeEncrypt, 32'd0, 150);

    quiesce();
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
